// File: rtl/stid_pkg.sv
// Shared types and constants for the sorted table block.
// Used by stid_cmp and sorted_table_insert_delete; depends on nothing.
package stid_pkg;

  localparam int unsigned Depth = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  typedef logic signed [DataW-1:0] data_t;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_DUMP   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_NOT_FOUND = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  // Result of the shared signed compare
  typedef struct packed {
    logic gt;
    logic eq;
  } cmp_t;

endpackage

// File: rtl/sorted_table_insert_delete.sv
// Sorted table with insert, delete and dump: sequencer, table memory, result register.
// Depends on stid_pkg and stid_cmp.
//
// Usage:
//   An item (mode_i, value_i) transfers at a rising edge with start high and busy low.
//   Insert and delete each give one result; a dump gives one result per entry, in
//   ascending order, with last_result_o on the final one. An empty dump gives a
//   single result with status empty. Mode 3 is dropped without a result.
//   Each result stands on the outputs for one cycle, marked by valid_o; the receiver
//   cannot stall, so results are never held back.
// Sequencing:
//   Insert walks the table from the top down through the single read port, one
//   entry per cycle, shifting larger entries up.
//   Delete runs a top-down search for the last match, then a shift pass over the
//   entries above it, one per cycle.
//   Dump streams one entry per cycle from the registered read port.
//   Full, empty and count-zero cases answer the cycle after the transfer.
//   busy stays high until the final result is issued; the table memory has one
//   write and one registered read port, which sets the one entry per cycle pace.
// Reset clears the entry count; no clearing pass is needed.
module sorted_table_insert_delete import stid_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         mode_i,
  input  logic signed [31:0] value_i,
  output logic               valid_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] entry_value_o,
  output logic [5:0]         entries_now_o,
  output logic               last_result_o
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_INS       = 6'b000010,
    ST_INS_FIN   = 6'b000100,
    ST_DEL_SRCH  = 6'b001000,
    ST_DEL_SHIFT = 6'b010000,
    ST_DUMP      = 6'b100000
  } state_e;

  state_e            state_q, state_d;
  logic [AddrW-1:0]  ptr_q, ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  data_t             val_q, val_d;

  // table memory
  data_t             mem_q [Depth];
  data_t             rdata_q;
  logic              rd_en;
  logic [AddrW-1:0]  rd_addr;
  logic              we;
  logic [AddrW-1:0]  wa;
  data_t             wd;

  // result register
  logic              emit;
  status_e           emit_status;
  data_t             emit_data;
  logic              emit_last;
  logic              valid_q;
  status_e           status_q;
  data_t             entry_q;
  logic              last_q;

  cmp_t              cmp;
  data_t             in_val;

  assign in_val = value_i[DataW-1:0];

  stid_cmp u_cmp (
    .entry_i   (rdata_q),
    .operand_i (val_q),
    .cmp_o     (cmp)
  );

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    count_d     = count_q;
    val_d       = val_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    we          = 1'b0;
    wa          = '0;
    wd          = val_q;
    emit        = 1'b0;
    emit_status = STATUS_OK;
    emit_data   = '0;
    emit_last   = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          val_d = in_val;
          case (mode_i)
            MODE_INSERT: begin
              if (count_q == CntW'(Depth)) begin
                emit        = 1'b1;
                emit_status = STATUS_FULL;
              end else if (count_q == '0) begin
                we      = 1'b1;
                wa      = '0;
                wd      = in_val;
                count_d = CntW'(1);
                emit    = 1'b1;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AddrW'(count_q - CntW'(1));
                ptr_d   = AddrW'(count_q - CntW'(1));
                state_d = ST_INS;
              end
            end
            MODE_DELETE: begin
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = STATUS_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = AddrW'(count_q - CntW'(1));
                ptr_d   = AddrW'(count_q - CntW'(1));
                state_d = ST_DEL_SRCH;
              end
            end
            MODE_DUMP: begin
              if (count_q == '0) begin
                emit        = 1'b1;
                emit_status = STATUS_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                ptr_d   = '0;
                state_d = ST_DUMP;
              end
            end
            default: begin
              // unused mode: drop the item
            end
          endcase
        end
      end

      ST_INS: begin
        we = 1'b1;
        wa = ptr_q + AddrW'(1);
        if (cmp.gt) begin
          // move the larger entry up and keep walking down
          wd = rdata_q;
          if (ptr_q == '0) begin
            state_d = ST_INS_FIN;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_q - AddrW'(1);
            ptr_d   = ptr_q - AddrW'(1);
          end
        end else begin
          wd      = val_q;
          count_d = count_q + CntW'(1);
          emit    = 1'b1;
          state_d = ST_IDLE;
        end
      end

      ST_INS_FIN: begin
        we      = 1'b1;
        wa      = '0;
        wd      = val_q;
        count_d = count_q + CntW'(1);
        emit    = 1'b1;
        state_d = ST_IDLE;
      end

      ST_DEL_SRCH: begin
        if (cmp.gt) begin
          if (ptr_q == '0) begin
            emit        = 1'b1;
            emit_status = STATUS_NOT_FOUND;
            state_d     = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_q - AddrW'(1);
            ptr_d   = ptr_q - AddrW'(1);
          end
        end else if (cmp.eq) begin
          if (CntW'(ptr_q) + CntW'(1) == count_q) begin
            count_d = count_q - CntW'(1);
            emit    = 1'b1;
            state_d = ST_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = ptr_q + AddrW'(1);
            state_d = ST_DEL_SHIFT;
          end
        end else begin
          emit        = 1'b1;
          emit_status = STATUS_NOT_FOUND;
          state_d     = ST_IDLE;
        end
      end

      ST_DEL_SHIFT: begin
        // rdata holds the entry above ptr: move it down
        we = 1'b1;
        wa = ptr_q;
        wd = rdata_q;
        if (CntW'(ptr_q) + CntW'(2) == count_q) begin
          count_d = count_q - CntW'(1);
          emit    = 1'b1;
          state_d = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = ptr_q + AddrW'(2);
          ptr_d   = ptr_q + AddrW'(1);
        end
      end

      ST_DUMP: begin
        emit      = 1'b1;
        emit_data = rdata_q;
        if (CntW'(ptr_q) + CntW'(1) == count_q) begin
          state_d = ST_IDLE;
        end else begin
          emit_last = 1'b0;
          rd_en     = 1'b1;
          rd_addr   = ptr_q + AddrW'(1);
          ptr_d     = ptr_q + AddrW'(1);
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q <= ptr_d;
    val_q <= val_d;
    if (emit) begin
      status_q <= emit_status;
      entry_q  <= emit_data;
      last_q   <= emit_last;
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign valid_o       = valid_q;
  assign status_o      = status_q;
  assign entry_value_o = 32'($signed(entry_q));
  assign entries_now_o = 6'(count_q);
  assign last_result_o = last_q;

endmodule

// File: rtl/stid_cmp.sv
// Shared signed compare unit: table entry against the operand value.
// Depends on stid_pkg.
module stid_cmp import stid_pkg::*; (
  input  data_t entry_i,
  input  data_t operand_i,
  output cmp_t  cmp_o
);

  assign cmp_o.gt = (entry_i > operand_i);
  assign cmp_o.eq = (entry_i == operand_i);

endmodule
